// ===== rtl/eiec_pkg.sv =====
package eiec_pkg;

  localparam int LINES    = 16;
  localparam int PORTS    = 4;
  localparam int SEL_W    = 2;
  localparam int IRQ_W    = 7;
  localparam int SOLO_IRQ = 5;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_PORT_SELECT    = 2'd0,
    REG_RISING_ENABLE  = 2'd1,
    REG_FALLING_ENABLE = 2'd2,
    REG_INTERRUPT_MASK = 2'd3
  } reg_index_t;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] port_a_levels;
    logic [15:0] port_b_levels;
    logic [15:0] port_c_levels;
    logic [15:0] port_d_levels;
    logic [15:0] clear_bits;
  } in_word_t;

  typedef struct packed {
    logic [15:0] pending_bits;
    logic [6:0]  irq_requests;
  } out_word_t;

  // per-line view of the configuration
  typedef struct packed {
    logic [SEL_W-1:0] sel;
    logic             rise_en;
    logic             fall_en;
    logic             mask;
  } lane_cfg_t;

  // per-line view of one input word
  typedef struct packed {
    cmd_t             command;
    logic [PORTS-1:0] levels;
    logic             clear;
  } lane_item_t;

endpackage

// ===== rtl/eiec_lane.sv =====
module eiec_lane #(
  parameter int PORT_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  eiec_pkg::lane_cfg_t  cfg,
  input  eiec_pkg::lane_item_t item,
  input  logic                accept,
  output logic                pending_next
);

  logic prev_level;
  logic pending;
  logic level;
  logic hit;
  logic [eiec_pkg::SEL_W:0] sel_wide;

  // an unknown port maps to port a
  always_comb begin
    sel_wide = {1'b0, cfg.sel};
    if (sel_wide < (eiec_pkg::SEL_W + 1)'(PORT_COUNT)) begin
      level = item.levels[cfg.sel];
    end else begin
      level = item.levels[0];
    end
  end

  assign hit = ((level & ~prev_level & cfg.rise_en) |
                (prev_level & ~level & cfg.fall_en)) & cfg.mask;

  always_comb begin
    unique case (item.command)
      eiec_pkg::CMD_SAMPLE: pending_next = pending | hit;
      eiec_pkg::CMD_CLEAR:  pending_next = pending & ~item.clear;
      default:              pending_next = pending;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= 1'b0;
      pending    <= 1'b0;
    end else if (accept) begin
      pending <= pending_next;
      if (item.command == eiec_pkg::CMD_SAMPLE) begin
        prev_level <= level;
      end
    end
  end

endmodule

// ===== rtl/eiec_merge.sv =====
module eiec_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         pend_next,
  input  logic [15:0]         mask,
  output logic                out_valid,
  input  logic                out_stall,
  output eiec_pkg::out_word_t out_word
);

  logic                main_valid;
  logic                skid_valid;
  eiec_pkg::out_word_t main_word;
  eiec_pkg::out_word_t skid_word;
  eiec_pkg::out_word_t new_word;
  logic [15:0]         req;
  logic                accept;
  logic                take;

  assign req = pend_next & mask;

  always_comb begin
    new_word.pending_bits = pend_next;
    new_word.irq_requests = {|req[15:10], |req[9:5], req[eiec_pkg::SOLO_IRQ-1:0]};
  end

  assign in_stall  = skid_valid;
  assign accept    = in_valid & ~skid_valid;
  assign take      = main_valid & ~out_stall;
  assign out_valid = main_valid;
  assign out_word  = main_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!accept) begin
        main_valid <= 1'b0;
      end
    end else if (accept) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  // payload: advance skid into main, or land the new word where there is room
  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        main_word <= skid_word;
      end else if (accept) begin
        main_word <= new_word;
      end
    end else if (accept) begin
      if (main_valid) begin
        skid_word <= new_word;
      end else begin
        main_word <= new_word;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid holds a word while main is empty");

  a_skid_fills: assert property (@(posedge clk) disable iff (rst)
    main_valid && out_stall && accept |=> skid_valid)
    else $error("accepted word behind a stalled result was dropped");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_stall |=> !skid_valid)
    else $error("skid did not drain when output was taken");

  a_irq_follows_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.irq_requests[4:0] & ~out_word.pending_bits[4:0]) == 5'd0)
    else $error("request raised without pending bit");
`endif

endmodule

// ===== rtl/external_interrupt_edge_controller_core.sv =====
// External interrupt edge controller, up to sixteen lines.
// Input channel (in_valid / in_stall / in_word): one word per cycle while not
// stalled. A sample word carries the levels of ports a to d; each line picks its pin
// through port_select and sets its pending bit on an enabled, unmasked edge.
// A clear word drops the pending bits given as ones in clear_bits.
// Output channel (out_valid / out_stall / out_word): one word per input word,
// with the pending bits and seven grouped requests (pending AND mask).
// The result of an accepted word is registered in the output buffer.
// Throughput is one word per cycle while in_stall is low, set by the per-line
// lane registers that update in the accepting cycle.
// A two-entry output buffer lets one more word in while a result is stalled;
// in_stall rises only when both entries are full and drops as soon as the
// receiver takes a word.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while the block is idle.
// Synchronous reset clears configuration, held levels, pending bits and the
// output buffer.
module external_interrupt_edge_controller_core #(
  parameter int LINE_COUNT = 16,
  parameter int PORT_COUNT = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  eiec_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output eiec_pkg::out_word_t  out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  eiec_pkg::reg_index_t cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [31:0] port_select;
  logic [15:0] rising_enable;
  logic [15:0] falling_enable;
  logic [15:0] interrupt_mask;
  logic [15:0] pend_next;
  logic        accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_select    <= '0;
      rising_enable  <= '0;
      falling_enable <= '0;
      interrupt_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        eiec_pkg::REG_PORT_SELECT:    port_select    <= cfg_data;
        eiec_pkg::REG_RISING_ENABLE:  rising_enable  <= cfg_data[15:0];
        eiec_pkg::REG_FALLING_ENABLE: falling_enable <= cfg_data[15:0];
        eiec_pkg::REG_INTERRUPT_MASK: interrupt_mask <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  for (genvar n = 0; n < eiec_pkg::LINES; n++) begin : g_line
    if (n < LINE_COUNT) begin : g_lane
      eiec_pkg::lane_cfg_t  lane_cfg;
      eiec_pkg::lane_item_t lane_item;

      always_comb begin
        lane_cfg.sel       = port_select[eiec_pkg::SEL_W*n +: eiec_pkg::SEL_W];
        lane_cfg.rise_en   = rising_enable[n];
        lane_cfg.fall_en   = falling_enable[n];
        lane_cfg.mask      = interrupt_mask[n];
        lane_item.command  = in_word.command;
        lane_item.levels   = {in_word.port_d_levels[n], in_word.port_c_levels[n],
                              in_word.port_b_levels[n], in_word.port_a_levels[n]};
        lane_item.clear    = in_word.clear_bits[n];
      end

      eiec_lane #(
        .PORT_COUNT(PORT_COUNT)
      ) u_lane (
        .clk         (clk),
        .rst         (rst),
        .cfg         (lane_cfg),
        .item        (lane_item),
        .accept      (accept),
        .pending_next(pend_next[n])
      );
    end else begin : g_none
      assign pend_next[n] = 1'b0;
    end
  end

  eiec_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .pend_next(pend_next),
    .mask     (interrupt_mask),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

endmodule

// ===== tb/sv/eiec_edge_checker.sv =====
module eiec_edge_checker #(
  parameter int LINE_COUNT = 16,
  parameter int PORT_COUNT = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  eiec_pkg::in_word_t   in_word,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  eiec_pkg::out_word_t  out_word,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  eiec_pkg::reg_index_t cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   mismatches,
  output int                   owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] LINE_SPAN =
      (LINE_COUNT >= 16) ? 16'hFFFF : 16'((1 << LINE_COUNT) - 1);

  logic [31:0]         sel_cfg;
  logic [15:0]         rise_cfg;
  logic [15:0]         fall_cfg;
  logic [15:0]         mask_cfg;
  logic [15:0]         held_levels;
  logic [15:0]         pend_flags;
  eiec_pkg::out_word_t owed_results[$];
  eiec_pkg::out_word_t oldest;

  initial mismatches = 0;

  task automatic flag_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // pin level each line sees through its port selector
  function automatic logic [15:0] line_levels(eiec_pkg::in_word_t w);
    logic [3:0][15:0] bank;
    logic [15:0]      lv;
    int               s;
    bank = {w.port_d_levels, w.port_c_levels, w.port_b_levels, w.port_a_levels};
    lv = '0;
    for (int n = 0; n < 16; n++) begin
      s = int'(sel_cfg[2*n +: 2]);
      // an unknown port reads as port a
      if (s >= PORT_COUNT) s = 0;
      lv[n] = bank[s][n];
    end
    return lv & LINE_SPAN;
  endfunction

  function automatic logic [6:0] group_irqs(logic [15:0] req);
    return {|req[15:10], |req[9:5], req[4:0]};
  endfunction

  function automatic eiec_pkg::out_word_t step_lines(eiec_pkg::in_word_t w);
    logic [15:0]         now;
    logic [15:0]         edges;
    eiec_pkg::out_word_t r;
    if (w.command == eiec_pkg::CMD_SAMPLE) begin
      now = line_levels(w);
      edges = (now & ~held_levels & rise_cfg) | (held_levels & ~now & fall_cfg);
      pend_flags = pend_flags | (edges & mask_cfg & LINE_SPAN);
      held_levels = now;
    end else begin
      pend_flags = pend_flags & ~w.clear_bits;
    end
    r.pending_bits = pend_flags;
    r.irq_requests = group_irqs(pend_flags & mask_cfg);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      sel_cfg = '0;
      rise_cfg = '0;
      fall_cfg = '0;
      mask_cfg = '0;
      held_levels = '0;
      pend_flags = '0;
      owed_results.delete();
    end else begin
      // check the outgoing word before queuing the incoming one
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected word %h", out_word));
        end else begin
          oldest = owed_results.pop_front();
          if (out_word.pending_bits !== oldest.pending_bits)
            flag_mismatch($sformatf("pending_bits got %h want %h",
                                    out_word.pending_bits, oldest.pending_bits));
          if (out_word.irq_requests !== oldest.irq_requests)
            flag_mismatch($sformatf("irq_requests got %h want %h",
                                    out_word.irq_requests, oldest.irq_requests));
        end
      end
      // a word taken at the same edge as a write still sees the old setting
      if (in_valid && !in_stall) owed_results.push_back(step_lines(in_word));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          eiec_pkg::REG_PORT_SELECT:    sel_cfg = cfg_data;
          eiec_pkg::REG_RISING_ENABLE:  rise_cfg = cfg_data[15:0];
          eiec_pkg::REG_FALLING_ENABLE: fall_cfg = cfg_data[15:0];
          eiec_pkg::REG_INTERRUPT_MASK: mask_cfg = cfg_data[15:0];
          default: ;
        endcase
      end
    end
    owed <= owed_results.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 100;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid;
  logic                 in_stall;
  eiec_pkg::in_word_t   in_word;
  logic                 out_valid;
  logic                 out_stall;
  eiec_pkg::out_word_t  out_word;
  logic                 cfg_valid;
  logic                 cfg_ready;
  eiec_pkg::reg_index_t cfg_index;
  logic [31:0]          cfg_data;

  int mismatches;
  int results_owed;
  int cycles = 0;
  int gap_free = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_active = 1'b0;
  logic [3:0][15:0] pins = '0;

  always #5 clk = ~clk;

  external_interrupt_edge_controller_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  eiec_edge_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .owed       (results_owed)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_active) begin
        out_stall <= 1'b1;
        hold_active = 1'b1;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 40)) @(posedge clk);
      end
    end
  end

  task automatic offer(eiec_pkg::in_word_t w);
    if (!quiet && gap_free == 0 && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
      gap_free = $urandom_range(0, 30);
    end else if (gap_free > 0) begin
      gap_free--;
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and wait for every owed result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(eiec_pkg::reg_index_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(logic [31:0] sel, logic [31:0] rise, logic [31:0] fall,
                              logic [31:0] mask);
    write_reg(eiec_pkg::REG_PORT_SELECT, sel);
    write_reg(eiec_pkg::REG_RISING_ENABLE, rise);
    write_reg(eiec_pkg::REG_FALLING_ENABLE, fall);
    write_reg(eiec_pkg::REG_INTERRUPT_MASK, mask);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic eiec_pkg::in_word_t sample_word(logic [15:0] a, logic [15:0] b,
                                                     logic [15:0] c, logic [15:0] d);
    eiec_pkg::in_word_t w;
    w.command = eiec_pkg::CMD_SAMPLE;
    w.port_a_levels = a;
    w.port_b_levels = b;
    w.port_c_levels = c;
    w.port_d_levels = d;
    w.clear_bits = 16'($urandom);
    return w;
  endfunction

  function automatic eiec_pkg::in_word_t clear_word(logic [15:0] bits);
    eiec_pkg::in_word_t w;
    w = sample_word(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    w.command = eiec_pkg::CMD_CLEAR;
    w.clear_bits = bits;
    return w;
  endfunction

  function automatic eiec_pkg::in_word_t rand_word();
    if ($urandom_range(0, 3) == 0)
      return clear_word(($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom & $urandom));
    // flip a few pins, now and then a whole port
    for (int p = 0; p < 4; p++)
      pins[p] ^= ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                              : 16'($urandom & $urandom & $urandom);
    return sample_word(pins[0], pins[1], pins[2], pins[3]);
  endfunction

  function automatic logic [31:0] biased_reg();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    in_valid <= 1'b0;
    in_word <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= eiec_pkg::REG_PORT_SELECT;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all lines on port a, both edges, wide values on the 16-bit registers
    program_regs(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(sample_word(16'hFFFF, 16'h0, 16'h0, 16'h0));
    offer(sample_word(16'hFFFF, 16'h0, 16'h0, 16'h0));
    offer(clear_word(16'h00FF));
    offer(clear_word(16'h0000));
    offer(sample_word(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    offer(clear_word(16'hFFFF));
    drain();

    // lines cycle through ports a..d, rising only, partial mask
    program_regs(32'hE4E4_E4E4, 32'h0000_FFFF, 32'h0, 32'h0000_A5A5);
    offer(sample_word(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    offer(sample_word(16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    offer(sample_word(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    offer(sample_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    drain();

    // all lines on port d, falling only
    program_regs(32'hFFFF_FFFF, 32'h0, 32'h0000_FFFF, 32'h0000_FFFF);
    offer(sample_word(16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
    offer(sample_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
    drain();

    // mask cleared: pending must hold with no requests
    program_regs(32'hFFFF_FFFF, 32'h0, 32'h0000_FFFF, 32'h0);
    offer(clear_word(16'h0000));
    offer(sample_word(16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
    drain();

    program_regs(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_8421);
    offer(clear_word(16'h0001));
    offer(sample_word(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    offer(sample_word(16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
    offer(clear_word(16'hFFFF));
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) quiet = 1'b1;
      program_regs(biased_reg(), biased_reg(), biased_reg(), biased_reg());
      if (ph == 2) begin
        // keep offering back to back while the receiver holds off
        hold_req = 1'b1;
        while (!hold_active) @(posedge clk);
        gap_free = 40;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 4 && i == PHASE_ITEMS / 2) drain();
        offer(rand_word());
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
